// ===== rtl/core/s2cd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package s2cd_pkg;

  // Port widths.
  localparam int unsigned SECS_W   = 32;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;

  // Calendar constants.
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned MINS_PER_HOUR  = 60;
  localparam int unsigned HOURS_PER_DAY  = 24;
  localparam int unsigned DAYS_PER_CYCLE = 4 * 365 + 1;
  localparam int unsigned LEAP_DAY_IDX   = 31 + 28;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned MAX_YEAR_OFS   = 99;
  localparam int unsigned BASE_YEAR      = 2000;

  // Internal widths along the divider chain.
  localparam int unsigned TOT_MIN_W  = 27;  // seconds / 60
  localparam int unsigned TOT_HOUR_W = 21;  // seconds / 3600
  localparam int unsigned TOT_DAY_W  = 16;  // seconds / 86400
  localparam int unsigned CYCLE_W    = 6;   // four-year cycles, at most 34
  localparam int unsigned DCYC_W     = 11;  // day inside a cycle, below 1461
  localparam int unsigned YOFS_W     = 8;   // year offset, at most 139
  localparam int unsigned DYEAR_W    = 9;   // day inside a year, below 366

  // Days before the first of each month, plus the year length at the end.
  localparam logic [DYEAR_W-1:0] CUM_DAYS [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  // Time of day, carried alongside the date arithmetic.
  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } tod_t;

endpackage

`default_nettype wire

// ===== rtl/core/s2cd_cdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-stage divider by a constant: a reciprocal multiply, then one
// compare-and-subtract correction step.
module s2cd_cdiv #(
  parameter int unsigned IN_W    = 32,
  parameter int unsigned DIVISOR = 60,
  parameter int unsigned Q_W     = 27,
  parameter int unsigned R_W     = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [IN_W-1:0] in_dividend,
  output logic            out_valid,
  output logic [Q_W-1:0]  out_quot,
  output logic [R_W-1:0]  out_rem
);

  // floor(2^IN_W / DIVISOR) underestimates the quotient by less than one.
  localparam logic [IN_W-1:0] MULT  = IN_W'((65'd1 << IN_W) / DIVISOR);
  localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);

  logic                v1_r;
  logic [2*IN_W-1:0]   prod_r;
  logic [2*IN_W-1:0]   prod_nxt;
  logic [IN_W-1:0]     dvd_r;

  logic                v2_r;
  logic [Q_W-1:0]      quot_r;
  logic [Q_W-1:0]      quot_nxt;
  logic [R_W-1:0]      rem_r;
  logic [R_W-1:0]      rem_nxt;

  logic [Q_W-1:0]      q_est;
  logic [IN_W-1:0]     q_times_d;
  logic [IN_W-1:0]     r_full;

  assign prod_nxt = (2*IN_W)'(in_dividend) * (2*IN_W)'(MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    dvd_r  <= in_dividend;
  end

  // The estimate is the true quotient or one less.
  always_comb begin
    q_est     = prod_r[IN_W +: Q_W];
    q_times_d = IN_W'(q_est) * DIV_C;
    r_full    = dvd_r - q_times_d;
    if (r_full >= DIV_C) begin
      quot_nxt = q_est + Q_W'(1);
      rem_nxt  = R_W'(r_full - DIV_C);
    end else begin
      quot_nxt = q_est;
      rem_nxt  = R_W'(r_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign out_valid = v2_r;
  assign out_quot  = quot_r;
  assign out_rem   = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (IN_W'(out_rem) < DIV_C))
    else $error("constant divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== rtl/core/s2cd_date.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Places the day inside its four-year cycle into year, month and day.
module s2cd_date
  import s2cd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [CYCLE_W-1:0] in_cycles,
  input  logic [DCYC_W-1:0]  in_dcyc,
  input  tod_t               in_tod,
  output logic               out_valid,
  output logic [YEAR_W-1:0]  out_year,
  output logic [MONTH_W-1:0] out_month,
  output logic [DAY_W-1:0]   out_day,
  output tod_t               out_tod
);

  localparam logic [DCYC_W-1:0] LEAP_C = DCYC_W'(LEAP_DAY_IDX);
  localparam logic [DCYC_W-1:0] Y1_C   = DCYC_W'(DAYS_PER_YEAR);
  localparam logic [DCYC_W-1:0] Y2_C   = DCYC_W'(2 * DAYS_PER_YEAR);
  localparam logic [DCYC_W-1:0] Y3_C   = DCYC_W'(3 * DAYS_PER_YEAR);

  // Stage one: year inside the cycle and day inside the year.
  logic               v1_r;
  logic [YOFS_W-1:0]  yofs_r;
  logic [YOFS_W-1:0]  yofs_nxt;
  logic [DYEAR_W-1:0] dyear_r;
  logic [DYEAR_W-1:0] dyear_nxt;
  logic               leap_r;
  logic               leap_nxt;
  tod_t               tod1_r;

  logic [DCYC_W-1:0]  d_adj;
  logic [1:0]         yq;

  always_comb begin
    leap_nxt = (in_dcyc == LEAP_C);
    d_adj    = (in_dcyc >= LEAP_C) ? (in_dcyc - DCYC_W'(1)) : in_dcyc;
    if (d_adj >= Y3_C) begin
      yq = 2'd3;
    end else if (d_adj >= Y2_C) begin
      yq = 2'd2;
    end else if (d_adj >= Y1_C) begin
      yq = 2'd1;
    end else begin
      yq = 2'd0;
    end
    case (yq)
      2'd1: begin
        dyear_nxt = DYEAR_W'(d_adj - Y1_C);
      end
      2'd2: begin
        dyear_nxt = DYEAR_W'(d_adj - Y2_C);
      end
      2'd3: begin
        dyear_nxt = DYEAR_W'(d_adj - Y3_C);
      end
      default: begin
        dyear_nxt = DYEAR_W'(d_adj);
      end
    endcase
    yofs_nxt = {in_cycles, yq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    yofs_r  <= yofs_nxt;
    dyear_r <= dyear_nxt;
    leap_r  <= leap_nxt;
    tod1_r  <= in_tod;
  end

  // Stage two: month lookup, day of month and the year clamp.
  logic               v2_r;
  logic [YEAR_W-1:0]  year_r;
  logic [YEAR_W-1:0]  year_nxt;
  logic [MONTH_W-1:0] month_r;
  logic [MONTH_W-1:0] month_nxt;
  logic [DAY_W-1:0]   day_r;
  logic [DAY_W-1:0]   day_nxt;
  tod_t               tod2_r;

  logic [DYEAR_W-1:0] dom;

  always_comb begin
    month_nxt = MONTH_W'(1);
    for (int i = 1; i < 12; i++) begin
      if (CUM_DAYS[i] <= dyear_r) begin
        month_nxt = MONTH_W'(i + 1);
      end
    end
    // February 29 sits on the same day index as February 28, so add it back.
    dom = dyear_r - CUM_DAYS[month_nxt - MONTH_W'(1)]
          + DYEAR_W'(leap_r) + DYEAR_W'(1);
    day_nxt = DAY_W'(dom);
    if (yofs_r > YOFS_W'(MAX_YEAR_OFS)) begin
      year_nxt = YEAR_W'(BASE_YEAR);
    end else begin
      year_nxt = YEAR_W'(BASE_YEAR) + YEAR_W'(yofs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    tod2_r  <= tod1_r;
  end

  assign out_valid = v2_r;
  assign out_year  = year_r;
  assign out_month = month_r;
  assign out_day   = day_r;
  assign out_tod   = tod2_r;

endmodule

`default_nettype wire

// ===== rtl/core/seconds_to_calendar_date.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts a 32-bit count of seconds since 2000-01-01 00:00:00 into year,
// month, day, hour, minute and second. The block is never busy: it takes a
// new beat in every cycle that start is high, and each result appears on the
// out_ ports for exactly one cycle, marked by out_valid. The receiver cannot
// stall the block, so it must take every result in the cycle it is shown.
// Each beat passes through four two-stage constant dividers in a chain (by
// 60, 60, 24 and 1461), each a reciprocal multiply followed by a correction,
// plus two stages that place the day in its year and month. Years past 2099
// read as 2000, while month, day and time still follow the plain four-year
// leap rule.
module seconds_to_calendar_date
  import s2cd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [SECS_W-1:0]   in_seconds_count,
  output logic                out_valid,
  output logic [YEAR_W-1:0]   out_year,
  output logic [MONTH_W-1:0]  out_month,
  output logic [DAY_W-1:0]    out_day,
  output logic [HOUR_W-1:0]   out_hour,
  output logic [MINUTE_W-1:0] out_minute,
  output logic [SECOND_W-1:0] out_second
);

  // The pipeline takes a beat in every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage A: total minutes and the second of the minute.
  logic                  a_valid;
  logic [TOT_MIN_W-1:0]  a_quot;
  logic [SECOND_W-1:0]   a_rem;

  s2cd_cdiv #(
    .IN_W    (SECS_W),
    .DIVISOR (SECS_PER_MIN),
    .Q_W     (TOT_MIN_W),
    .R_W     (SECOND_W)
  ) u_div_sec (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (accept),
    .in_dividend (in_seconds_count),
    .out_valid   (a_valid),
    .out_quot    (a_quot),
    .out_rem     (a_rem)
  );

  // Stage B: total hours and the minute of the hour.
  logic                  b_valid;
  logic [TOT_HOUR_W-1:0] b_quot;
  logic [MINUTE_W-1:0]   b_rem;

  s2cd_cdiv #(
    .IN_W    (TOT_MIN_W),
    .DIVISOR (MINS_PER_HOUR),
    .Q_W     (TOT_HOUR_W),
    .R_W     (MINUTE_W)
  ) u_div_min (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (a_valid),
    .in_dividend (a_quot),
    .out_valid   (b_valid),
    .out_quot    (b_quot),
    .out_rem     (b_rem)
  );

  // Stage C: whole days and the hour of the day.
  logic                  c_valid;
  logic [TOT_DAY_W-1:0]  c_quot;
  logic [HOUR_W-1:0]     c_rem;

  s2cd_cdiv #(
    .IN_W    (TOT_HOUR_W),
    .DIVISOR (HOURS_PER_DAY),
    .Q_W     (TOT_DAY_W),
    .R_W     (HOUR_W)
  ) u_div_hour (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (b_valid),
    .in_dividend (b_quot),
    .out_valid   (c_valid),
    .out_quot    (c_quot),
    .out_rem     (c_rem)
  );

  // Stage D: four-year cycles and the day inside the cycle.
  logic                  d_valid;
  logic [CYCLE_W-1:0]    d_quot;
  logic [DCYC_W-1:0]     d_rem;

  s2cd_cdiv #(
    .IN_W    (TOT_DAY_W),
    .DIVISOR (DAYS_PER_CYCLE),
    .Q_W     (CYCLE_W),
    .R_W     (DCYC_W)
  ) u_div_cycle (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (c_valid),
    .in_dividend (c_quot),
    .out_valid   (d_valid),
    .out_quot    (d_quot),
    .out_rem     (d_rem)
  );

  // The time-of-day fields leave the chain early. These delay lines keep
  // them lined up with the date of the same beat; no reset is needed since
  // the valid bits in the dividers qualify them.
  logic [SECOND_W-1:0] sec_dly_r [6];
  logic [MINUTE_W-1:0] min_dly_r [4];
  logic [HOUR_W-1:0]   hrs_dly_r [2];

  always_ff @(posedge clk) begin
    sec_dly_r[0] <= a_rem;
    for (int i = 1; i < 6; i++) begin
      sec_dly_r[i] <= sec_dly_r[i-1];
    end
    min_dly_r[0] <= b_rem;
    for (int i = 1; i < 4; i++) begin
      min_dly_r[i] <= min_dly_r[i-1];
    end
    hrs_dly_r[0] <= c_rem;
    hrs_dly_r[1] <= hrs_dly_r[0];
  end

  tod_t d_tod;
  assign d_tod = '{hour: hrs_dly_r[1], minute: min_dly_r[3], second: sec_dly_r[5]};

  // Stages E and F: calendar placement.
  tod_t f_tod;

  s2cd_date u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_cycles (d_quot),
    .in_dcyc   (d_rem),
    .in_tod    (d_tod),
    .out_valid (out_valid),
    .out_year  (out_year),
    .out_month (out_month),
    .out_day   (out_day),
    .out_tod   (f_tod)
  );

  assign out_hour   = f_tod.hour;
  assign out_minute = f_tod.minute;
  assign out_second = f_tod.second;

  // Every accepted beat yields exactly one result.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##10 out_valid)
    else $error("accepted beat produced no result after ten cycles");

  a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 10))
    else $error("result without an accepted beat ten cycles earlier");

  a_date_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year >= YEAR_W'(BASE_YEAR)) &&
                  (out_year <= YEAR_W'(BASE_YEAR + MAX_YEAR_OFS)) &&
                  (out_month >= MONTH_W'(1)) && (out_month <= MONTH_W'(12)) &&
                  (out_day >= DAY_W'(1)))
    else $error("calendar date out of range");

  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour < HOUR_W'(HOURS_PER_DAY)) &&
                  (out_minute < MINUTE_W'(MINS_PER_HOUR)) &&
                  (out_second < SECOND_W'(SECS_PER_MIN)))
    else $error("time of day out of range");

endmodule

`default_nettype wire

// ===== sim/calendar_date_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the calendar converter. Every accepted input beat
// gets its expected date computed here, and every result beat is compared
// with the oldest date still waiting.
module calendar_date_checker
  import s2cd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [SECS_W-1:0]   in_seconds_count,
  input  logic                out_valid,
  input  logic [YEAR_W-1:0]   out_year,
  input  logic [MONTH_W-1:0]  out_month,
  input  logic [DAY_W-1:0]    out_day,
  input  logic [HOUR_W-1:0]   out_hour,
  input  logic [MINUTE_W-1:0] out_minute,
  input  logic [SECOND_W-1:0] out_second,
  output int                  mismatch_count,
  output int                  dates_in_flight
);

  localparam int unsigned DAY_SECS      = 86400;
  localparam int unsigned HOUR_SECS     = 3600;
  localparam int unsigned MINUTE_SECS   = 60;
  localparam int unsigned CYCLE_DAYS    = 1461;
  localparam int unsigned LEAP_DAY      = 59;
  localparam int unsigned YEAR_DAYS     = 365;
  localparam int unsigned LAST_YEAR_OFS = 99;
  localparam int unsigned FIRST_YEAR    = 2000;

  localparam int unsigned MONTH_FIRST_DAY [13] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
  };

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } calendar_date_t;

  calendar_date_t expected_dates [$];

  initial begin
    mismatch_count  = 0;
    dates_in_flight = 0;
  end

  function automatic calendar_date_t date_of(input logic [SECS_W-1:0] secs);
    int unsigned    total;
    int unsigned    days;
    int unsigned    cycle_num;
    int unsigned    day_in_cycle;
    int unsigned    year_ofs;
    int unsigned    day_in_year;
    int unsigned    month_num;
    int unsigned    m;
    bit             leap_day;
    calendar_date_t d;
    total        = secs;
    days         = total / DAY_SECS;
    cycle_num    = days / CYCLE_DAYS;
    day_in_cycle = days % CYCLE_DAYS;
    // February 29 sits at a fixed day of each four-year cycle; folding it onto
    // February 28 lets every year of the cycle use the 365-day table.
    leap_day = (day_in_cycle == LEAP_DAY);
    if (day_in_cycle >= LEAP_DAY) begin
      day_in_cycle = day_in_cycle - 1;
    end
    year_ofs    = cycle_num * 4 + day_in_cycle / YEAR_DAYS;
    day_in_year = day_in_cycle % YEAR_DAYS;
    month_num   = 1;
    for (m = 1; m < 12; m++) begin
      if (MONTH_FIRST_DAY[m] <= day_in_year) begin
        month_num = m + 1;
      end
    end
    if (year_ofs > LAST_YEAR_OFS) begin
      year_ofs = 0;
    end
    d.year   = YEAR_W'(year_ofs + FIRST_YEAR);
    d.month  = MONTH_W'(month_num);
    d.day    = DAY_W'(day_in_year - MONTH_FIRST_DAY[month_num - 1] + (leap_day ? 2 : 1));
    d.hour   = HOUR_W'((total / HOUR_SECS) % 24);
    d.minute = MINUTE_W'((total / MINUTE_SECS) % 60);
    d.second = SECOND_W'(total % MINUTE_SECS);
    return d;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    calendar_date_t want;
    if (rst_n) begin
      if (start && !busy) begin
        expected_dates.push_back(date_of(in_seconds_count));
      end
      if (out_valid) begin
        if (expected_dates.size() == 0) begin
          $error("out beat arrived with no date pending");
          mismatch_count++;
        end else begin
          want = expected_dates.pop_front();
          check_field("year", want.year, out_year);
          check_field("month", want.month, out_month);
          check_field("day", want.day, out_day);
          check_field("hour", want.hour, out_hour);
          check_field("minute", want.minute, out_minute);
          check_field("second", want.second, out_second);
        end
      end
    end
    dates_in_flight <= expected_dates.size();
  end

endmodule

// ===== sim/seconds_to_calendar_date_tb.sv =====
`timescale 1ns / 1ps

// Top of the calendar converter bench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts every date and
// counts the mismatches.
module seconds_to_calendar_date_tb;
  import s2cd_pkg::*;

  localparam int unsigned DAY_SECS      = 86400;
  localparam int          RANDOM_BEATS  = 1500;
  // Beats in this window go out back to back, with no idling at all.
  localparam int          QUIET_FIRST   = 500;
  localparam int          QUIET_LAST    = 800;
  // The tail wait is longer than the pipeline is deep.
  localparam int          TAIL_CYCLES   = 20;
  // Around this count the year field wraps from 2099 back to 2000.
  localparam int unsigned CENTURY_WRAP  = 32'd3155760000;

  // Landmark counts: the first and last counts, every edge of the time of day,
  // the leap day of 2000 with its neighbors, the leap day of 2004, the end of
  // February 2001, leap and plain year ends, the wrap from 2099 into the forced
  // year 2000, the leap day the plain four-year rule gives 2100, and bit patterns.
  localparam logic [SECS_W-1:0] LANDMARK_COUNTS [25] = '{
    32'd0,          32'd59,         32'd60,         32'd3599,       32'd3600,
    32'd86399,      32'd86400,      32'd5097599,    32'd5097600,    32'd5183999,
    32'd5184000,    32'd31622399,   32'd31622400,   32'd36719999,   32'd36720000,
    32'd126230399,  32'd126230400,  32'd131328000,  32'd3155759999, 32'd3155760000,
    32'd3160857600, 32'h7FFF_FFFF,  32'h8000_0000,  32'hAAAA_AAAA,  32'hFFFF_FFFF
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [SECS_W-1:0]   in_seconds_count = '0;
  logic                out_valid;
  logic [YEAR_W-1:0]   out_year;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;
  logic [HOUR_W-1:0]   out_hour;
  logic [MINUTE_W-1:0] out_minute;
  logic [SECOND_W-1:0] out_second;
  int                  mismatch_count;
  int                  dates_in_flight;

  always #5 clk = ~clk;

  seconds_to_calendar_date uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_seconds_count (in_seconds_count),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

  calendar_date_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_seconds_count (in_seconds_count),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .mismatch_count   (mismatch_count),
    .dates_in_flight  (dates_in_flight)
  );

  // Presents one beat from the falling edge and holds it until a rising edge
  // sees busy low. Start is left high, so the next beat or gap decides its
  // value at the next falling edge with a single assignment.
  task automatic send_count(input logic [SECS_W-1:0] secs);
    @(negedge clk);
    start            <= 1'b1;
    in_seconds_count <= secs;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Idle cycles carry random data so that the block has to ignore it.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start            <= 1'b0;
      in_seconds_count <= $urandom;
    end
  endtask

  // Holds the sender off until every date in flight has been checked.
  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (dates_in_flight != 0) begin
      @(posedge clk);
    end
  endtask

  // An idle gap now and then, before about 39 beats in a hundred.
  task automatic maybe_idle(input int beat_idx);
    if ((beat_idx < QUIET_FIRST || beat_idx > QUIET_LAST) &&
        $urandom_range(0, 99) < 39) begin
      idle_cycles(1);
    end
  endtask

  // A count close to a month or year boundary somewhere in the 32-bit range,
  // at the first second, the last second or a random second of that day.
  function automatic logic [SECS_W-1:0] boundary_count();
    int unsigned cycle_num;
    int unsigned year_in_cycle;
    int unsigned month_idx;
    int unsigned day_in_cycle;
    int unsigned sod;
    cycle_num     = $urandom_range(0, 33);
    year_in_cycle = $urandom_range(0, 3);
    month_idx     = $urandom_range(0, 12);
    // The first year of a cycle is the leap year, so its months from March on
    // start one day later than the table says.
    if (year_in_cycle == 0) begin
      day_in_cycle = CUM_DAYS[month_idx] + ((month_idx >= 2) ? 1 : 0);
    end else begin
      day_in_cycle = 366 + (year_in_cycle - 1) * 365 + CUM_DAYS[month_idx];
    end
    day_in_cycle = day_in_cycle + $urandom_range(0, 2);
    if (day_in_cycle != 0) begin
      day_in_cycle = day_in_cycle - 1;
    end
    case ($urandom_range(0, 2))
      0:       sod = 0;
      1:       sod = DAY_SECS - 1;
      default: sod = $urandom_range(0, DAY_SECS - 1);
    endcase
    return (cycle_num * 1461 + day_in_cycle) * DAY_SECS + sod;
  endfunction

  function automatic logic [SECS_W-1:0] random_count();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5, 6: return boundary_count();
      7: return CENTURY_WRAP - 2 * DAY_SECS + $urandom_range(0, 4 * DAY_SECS);
      default: return $urandom_range(0, 49709) * DAY_SECS + $urandom_range(0, DAY_SECS - 1);
    endcase
  endfunction

  initial begin
    int beat_idx;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed landmarks first.
    for (beat_idx = 0; beat_idx < 25; beat_idx++) begin
      maybe_idle(RANDOM_BEATS);
      send_count(LANDMARK_COUNTS[beat_idx]);
    end

    // Random beats, with the sender held off twice until the block is empty.
    for (beat_idx = 0; beat_idx < RANDOM_BEATS; beat_idx++) begin
      if (beat_idx == 300 || beat_idx == 1100) begin
        drain_pipeline();
      end
      maybe_idle(beat_idx);
      send_count(random_count());
    end

    drain_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: stops a run that never finishes.
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
